// ----- src/front_to_back_color_accumulator_macros.svh -----
// Assertion macros for the front-to-back color accumulator.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef FRONT_TO_BACK_COLOR_ACCUMULATOR_MACROS_SVH
`define FRONT_TO_BACK_COLOR_ACCUMULATOR_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled during reset.
`define FTBCA_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("ftbca assertion failed");

// Next-cycle implication, disabled during reset.
`define FTBCA_ASSERT_NXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("ftbca assertion failed");

`else

`define FTBCA_ASSERT_IMP(label, ck, rn, ante, cons)
`define FTBCA_ASSERT_NXT(label, ck, rn, ante, cons)

`endif

`endif

// ----- src/ftbca_pkg.sv -----
// Shared types, constants and division helpers for the color accumulator.
// No dependencies; imported by the controller, datapath and top level.
package ftbca_pkg;

    localparam int unsigned CHANNELS = 3;
    localparam int unsigned GAIN_FRAC_BITS = 12;

    localparam logic [15:0] FULL_SCALE = 16'hFFFF;
    localparam logic [16:0] FULL_SCALE_17 = 17'd65535;
    localparam logic [17:0] FULL_SCALE_18 = 18'd65535;
    localparam logic [17:0] TWO_FULL_SCALE_18 = 18'd131070;

    // Commands from the controller to the datapath, one per step.
    typedef struct packed {
        logic load;
        logic mul_at;
        logic mul_c;
        logic div1;
        logic div2;
        logic commit;
    } ftbca_cmd_t;

    // Floor division of a value below 65535*65535 by 65535.
    // With x = hi*65536 + lo, x = hi*65535 + (hi + lo), and hi + lo stays
    // below twice 65535, so one compare finishes the quotient.
    function automatic logic [15:0] div_full_32(input logic [31:0] x);
        logic [16:0] s;
        logic [16:0] q;
        s = {1'b0, x[31:16]} + {1'b0, x[15:0]};
        q = {1'b0, x[31:16]} + {16'b0, (s >= FULL_SCALE_17)};
        return q[15:0];
    endfunction

    // Floor division of a value below 65535^3 by 65535.
    // The same folding is applied twice; the last remainder stays below
    // three times 65535, so two compares give the final correction.
    function automatic logic [31:0] div_full_48(input logic [47:0] x);
        logic [32:0] y;
        logic [17:0] s;
        logic [1:0]  corr;
        logic [33:0] q;
        y = {1'b0, x[47:16]} + {17'b0, x[15:0]};
        s = {1'b0, y[32:16]} + {2'b0, y[15:0]};
        if (s >= TWO_FULL_SCALE_18) begin
            corr = 2'd2;
        end else if (s >= FULL_SCALE_18) begin
            corr = 2'd1;
        end else begin
            corr = 2'd0;
        end
        q = {2'b0, x[47:16]} + {17'b0, y[32:16]} + {32'b0, corr};
        return q[31:0];
    endfunction

endpackage

// ----- src/ftbca_ctrl.sv -----
// Step sequencer and output handshake for the color accumulator.
// Depends on ftbca_pkg and the assertion macro header.
`include "front_to_back_color_accumulator_macros.svh"

module ftbca_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output ftbca_pkg::ftbca_cmd_t cmd
);
    import ftbca_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL_AT = 3'd1;
    localparam logic [2:0] ST_MUL_C  = 3'd2;
    localparam logic [2:0] ST_DIV1   = 3'd3;
    localparam logic [2:0] ST_DIV2   = 3'd4;
    localparam logic [2:0] ST_BLEND  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       out_free;

    // A new transaction is taken only while no sample is in flight.
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Step commands for the datapath.
    always_comb
    begin
        cmd.load   = accept;
        cmd.mul_at = (state_reg == ST_MUL_AT);
        cmd.mul_c  = (state_reg == ST_MUL_C);
        cmd.div1   = (state_reg == ST_DIV1);
        cmd.div2   = (state_reg == ST_DIV2);
        cmd.commit = (state_reg == ST_BLEND) && out_free;
    end

    // Next state: a fixed walk through the steps, holding in the blend
    // step until the output register can take the new result.
    always_comb
    begin
        case (state_reg)
            ST_IDLE:   state_next = accept ? ST_MUL_AT : ST_IDLE;
            ST_MUL_AT: state_next = ST_MUL_C;
            ST_MUL_C:  state_next = ST_DIV1;
            ST_DIV1:   state_next = ST_DIV2;
            ST_DIV2:   state_next = ST_BLEND;
            ST_BLEND:  state_next = out_free ? ST_IDLE : ST_BLEND;
            default:   state_next = ST_IDLE;
        endcase
    end

    // The result stays valid until the receiver takes it.
    always_comb
    begin
        out_valid_next = cmd.commit || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // An accepted sample always starts with the first multiply.
    `FTBCA_ASSERT_NXT(a_accept_starts, clk, rst_n, accept, state_reg == ST_MUL_AT)
    // A commit never overwrites a result that is still held.
    `FTBCA_ASSERT_IMP(a_commit_free, clk, rst_n, cmd.commit, !(out_valid_reg && out_stall))
    // A new result only appears out of the blend step.
    `FTBCA_ASSERT_IMP(a_valid_from_blend, clk, rst_n, $rose(out_valid_reg),
                      $past(state_reg) == ST_BLEND)
    // Blend with a free output register always delivers.
    `FTBCA_ASSERT_NXT(a_blend_delivers, clk, rst_n,
                      (state_reg == ST_BLEND) && !out_valid_reg, out_valid_reg)

endmodule

// ----- src/ftbca_datapath.sv -----
// Multiply, divide-by-constant and blend lanes of the color accumulator.
// Depends on ftbca_pkg for the command struct and division helpers.
module ftbca_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ftbca_pkg::ftbca_cmd_t cmd,
    input  logic                  start_ray,
    input  logic [15:0]           sample_red,
    input  logic [15:0]           sample_green,
    input  logic [15:0]           sample_blue,
    input  logic [15:0]           sample_alpha,
    input  logic [15:0]           light_red,
    input  logic [15:0]           light_green,
    input  logic [15:0]           light_blue,
    output logic [15:0]           acc_red_out,
    output logic [15:0]           acc_green_out,
    output logic [15:0]           acc_blue_out,
    output logic [15:0]           transmittance_out
);
    import ftbca_pkg::*;

    // Ray state.
    logic [CHANNELS-1:0][15:0] acc_reg;
    logic [15:0]               trans_reg;

    // Captured sample.
    logic [CHANNELS-1:0][15:0] color_reg;
    logic [CHANNELS-1:0][15:0] gain_reg;
    logic [CHANNELS-1:0][15:0] base_reg;
    logic [15:0]               alpha_reg;
    logic [15:0]               t_use_reg;

    // Intermediate results.
    logic [31:0]               at_reg;
    logic [31:0]               tprod_reg;
    logic [15:0]               t_new_reg;
    logic [CHANNELS-1:0][47:0] x_reg;
    logic [CHANNELS-1:0][31:0] q1_reg;
    logic [CHANNELS-1:0][15:0] w_reg;

    logic [CHANNELS-1:0][15:0] color_in;
    logic [CHANNELS-1:0][15:0] gain_in;
    logic [CHANNELS-1:0][15:0] acc_next;

    // Full 16 by 16 product.
    function automatic logic [31:0] sample_alpha_times(input logic [15:0] a,
                                                       input logic [15:0] b);
        return {16'b0, a} * {16'b0, b};
    endfunction

    assign color_in = {sample_blue, sample_green, sample_red};
    assign gain_in  = {light_blue, light_green, light_red};

    // Blend: gain in Q4.12, truncated, then a saturating add.
    always_comb
    begin
        logic [31:0] gprod;
        logic [19:0] add;
        logic [20:0] sum;
        for (int i = 0; i < CHANNELS; i++)
        begin
            gprod = w_reg[i] * gain_reg[i];
            add   = gprod[31:GAIN_FRAC_BITS];
            sum   = {5'b0, base_reg[i]} + {1'b0, add};
            if (sum >= {5'b0, FULL_SCALE})
            begin
                acc_next[i] = FULL_SCALE;
            end
            else
            begin
                acc_next[i] = sum[15:0];
            end
        end
    end

    // Sample capture and step registers; a ray start clears the base.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            color_reg <= color_in;
            gain_reg  <= gain_in;
            alpha_reg <= sample_alpha;
            base_reg  <= start_ray ? '0 : acc_reg;
            t_use_reg <= start_ray ? FULL_SCALE : trans_reg;
        end
        if (cmd.mul_at)
        begin
            at_reg    <= sample_alpha_times(alpha_reg, t_use_reg);
            tprod_reg <= sample_alpha_times(~alpha_reg, t_use_reg);
        end
        if (cmd.mul_c)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                x_reg[i] <= {32'b0, color_reg[i]} * {16'b0, at_reg};
            end
            t_new_reg <= div_full_32(tprod_reg);
        end
        if (cmd.div1)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                q1_reg[i] <= div_full_48(x_reg[i]);
            end
        end
        if (cmd.div2)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                w_reg[i] <= div_full_32(q1_reg[i]);
            end
        end
    end

    // Accumulators and transmittance change only when a result commits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            trans_reg <= FULL_SCALE;
        end
        else if (cmd.commit)
        begin
            acc_reg   <= acc_next;
            trans_reg <= t_new_reg;
        end
    end

    assign acc_red_out       = acc_reg[0];
    assign acc_green_out     = acc_reg[1];
    assign acc_blue_out      = acc_reg[2];
    assign transmittance_out = trans_reg;

endmodule

// ----- src/front_to_back_color_accumulator.sv -----
// Top level of the front-to-back color accumulator.
// Depends on ftbca_pkg, ftbca_ctrl and ftbca_datapath.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------------
//   input   | in_valid, in_stall | start_ray, sample_*, light_*
//   output  | out_valid,out_stall| acc_*_out, transmittance_out
//
// A sample is captured at its accepting edge and five steps follow: two multiply
// steps, two divide-by-65535 steps and the blend step. The result is valid after
// the fifth step, and a new sample is taken only once that step has committed it.
// Reset clears the accumulators and sets the transmittance to full scale.
// The input is stalled while a sample is in flight; a result held by
// out_stall keeps the next sample waiting in its blend step, while its earlier steps go on.
module front_to_back_color_accumulator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        start_ray,
    input  logic [15:0] sample_red,
    input  logic [15:0] sample_green,
    input  logic [15:0] sample_blue,
    input  logic [15:0] sample_alpha,
    input  logic [15:0] light_red,
    input  logic [15:0] light_green,
    input  logic [15:0] light_blue,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] acc_red_out,
    output logic [15:0] acc_green_out,
    output logic [15:0] acc_blue_out,
    output logic [15:0] transmittance_out
);
    import ftbca_pkg::*;

    ftbca_cmd_t cmd;

    // Sequencer.
    ftbca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Arithmetic lanes and ray state.
    ftbca_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .start_ray         (start_ray),
        .sample_red        (sample_red),
        .sample_green      (sample_green),
        .sample_blue       (sample_blue),
        .sample_alpha      (sample_alpha),
        .light_red         (light_red),
        .light_green       (light_green),
        .light_blue        (light_blue),
        .acc_red_out       (acc_red_out),
        .acc_green_out     (acc_green_out),
        .acc_blue_out      (acc_blue_out),
        .transmittance_out (transmittance_out)
    );

endmodule

// ----- sim/front_to_back_color_accumulator_tb.sv -----
// Self-checking testbench for the front-to-back color accumulator.
// Depends only on the RTL (ftbca_pkg and front_to_back_color_accumulator).
// A local compositing predictor checks every result against its own model of the ray state.
module front_to_back_color_accumulator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned ALPHA_T_DIVISOR = 64'd4294836225;
    localparam longint unsigned FULL_LEVEL      = 64'd65535;
    localparam int unsigned     GAIN_SHIFT      = 12;
    localparam logic [15:0]     UNITY_GAIN      = 16'd4096;
    localparam int unsigned     CYCLE_LIMIT     = 400000;
    localparam int unsigned     DRAIN_CYCLES    = 20;

    // One sample as it enters the block.
    typedef struct packed {
        logic        start;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha;
        logic [15:0] gain_red;
        logic [15:0] gain_green;
        logic [15:0] gain_blue;
    } sample_t;

    // One composited pixel as it leaves the block.
    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] transmittance;
    } pixel_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        start_ray = 1'b0;
    logic [15:0] sample_red = '0;
    logic [15:0] sample_green = '0;
    logic [15:0] sample_blue = '0;
    logic [15:0] sample_alpha = '0;
    logic [15:0] light_red = '0;
    logic [15:0] light_green = '0;
    logic [15:0] light_blue = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] acc_red_out;
    logic [15:0] acc_green_out;
    logic [15:0] acc_blue_out;
    logic [15:0] transmittance_out;

    // Predicted ray state and the pixels still owed by the block.
    logic [15:0] ray_red = '0;
    logic [15:0] ray_green = '0;
    logic [15:0] ray_blue = '0;
    logic [15:0] ray_transmittance = 16'hFFFF;
    pixel_t      expected_pixels[$];
    pixel_t      oldest_pixel;

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    logic        steady = 1'b0;

    front_to_back_color_accumulator DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .start_ray         (start_ray),
        .sample_red        (sample_red),
        .sample_green      (sample_green),
        .sample_blue       (sample_blue),
        .sample_alpha      (sample_alpha),
        .light_red         (light_red),
        .light_green       (light_green),
        .light_blue        (light_blue),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .acc_red_out       (acc_red_out),
        .acc_green_out     (acc_green_out),
        .acc_blue_out      (acc_blue_out),
        .transmittance_out (transmittance_out)
    );

    always #5 clk = ~clk;

    // Adds one channel's weighted, gained contribution and saturates at full scale.
    function automatic logic [15:0] blend_weighted(input logic [15:0] acc,
                                                   input logic [15:0] color,
                                                   input logic [15:0] alpha,
                                                   input logic [15:0] trans,
                                                   input logic [15:0] gain);
        longint unsigned weight;
        longint unsigned contribution;
        longint unsigned sum;
        weight = (64'(color) * 64'(alpha) * 64'(trans)) / ALPHA_T_DIVISOR;
        contribution = (weight * 64'(gain)) >> GAIN_SHIFT;
        sum = 64'(acc) + contribution;
        return (sum >= FULL_LEVEL) ? 16'hFFFF : sum[15:0];
    endfunction

    // Composites one sample onto the predicted ray and returns the pixel after it.
    function automatic pixel_t composite_sample(input sample_t s);
        longint unsigned remaining;
        if (s.start) begin
            ray_red = '0;
            ray_green = '0;
            ray_blue = '0;
            ray_transmittance = 16'hFFFF;
        end
        ray_red = blend_weighted(ray_red, s.red, s.alpha, ray_transmittance, s.gain_red);
        ray_green = blend_weighted(ray_green, s.green, s.alpha, ray_transmittance, s.gain_green);
        ray_blue = blend_weighted(ray_blue, s.blue, s.alpha, ray_transmittance, s.gain_blue);
        remaining = (64'(ray_transmittance) * (FULL_LEVEL - 64'(s.alpha))) / FULL_LEVEL;
        ray_transmittance = remaining[15:0];
        return '{red: ray_red, green: ray_green, blue: ray_blue,
                 transmittance: ray_transmittance};
    endfunction

    function automatic sample_t make_sample(input logic start,
                                            input logic [15:0] red, input logic [15:0] green,
                                            input logic [15:0] blue, input logic [15:0] alpha,
                                            input logic [15:0] gain_r, input logic [15:0] gain_g,
                                            input logic [15:0] gain_b);
        return '{start: start, red: red, green: green, blue: blue, alpha: alpha,
                 gain_red: gain_r, gain_green: gain_g, gain_blue: gain_b};
    endfunction

    // Colors lean toward the extremes now and then.
    function automatic logic [15:0] pick_color();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Gains mostly sit near unity so rays build up before they saturate.
    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(2048, 8192));
        endcase
    endfunction

    // Small opacities keep the transmittance alive deep into a ray.
    function automatic logic [15:0] pick_alpha();
        case ($urandom_range(0, 9))
            0:          return 16'h0000;
            1:          return 16'hFFFF;
            2, 3, 4, 5: return 16'($urandom_range(0, 4095));
            default:    return 16'($urandom);
        endcase
    endfunction

    function automatic sample_t random_sample(input logic start);
        return make_sample(start, pick_color(), pick_color(), pick_color(), pick_alpha(),
                           pick_gain(), pick_gain(), pick_gain());
    endfunction

    // Drives one transaction, holds it until accepted, then records the expected pixel.
    task automatic send_sample(input sample_t s);
        while (!steady && $urandom_range(0, 99) < 11) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        start_ray    <= s.start;
        sample_red   <= s.red;
        sample_green <= s.green;
        sample_blue  <= s.blue;
        sample_alpha <= s.alpha;
        light_red    <= s.gain_red;
        light_green  <= s.gain_green;
        light_blue   <= s.gain_blue;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        expected_pixels.push_back(composite_sample(s));
    endtask

    // Holds off the sender until every owed pixel has come back.
    task automatic wait_for_pixels();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0) begin
            @(posedge clk);
        end
    endtask

    // Samples without a start mark right after reset continue the reset ray.
    task automatic test_reset_ray();
        send_sample(make_sample(1'b0, 16'hFFFF, 16'h8000, 16'h0001, 16'h8000,
                                UNITY_GAIN, UNITY_GAIN, UNITY_GAIN));
        send_sample(make_sample(1'b0, 16'h1234, 16'hFFFF, 16'h4321, 16'h4000,
                                UNITY_GAIN, 16'h2000, 16'h0800));
    endtask

    // All-zero and all-one fields, plus a transparent sample.
    task automatic test_field_extremes();
        send_sample(make_sample(1'b1, '0, '0, '0, '0, '0, '0, '0));
        send_sample(make_sample(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000,
                                16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_sample(make_sample(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                UNITY_GAIN, UNITY_GAIN, UNITY_GAIN));
        send_sample(make_sample(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_sample(make_sample(1'b1, 16'h0000, 16'hFFFF, 16'h0000, 16'h0001,
                                16'h0001, 16'hFFFF, 16'h0000));
    endtask

    // An opaque sample closes the ray; later samples add nothing.
    task automatic test_opaque_sample();
        send_sample(make_sample(1'b1, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF,
                                UNITY_GAIN, UNITY_GAIN, UNITY_GAIN));
        send_sample(make_sample(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000,
                                16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_sample(make_sample(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_sample(make_sample(1'b1, 16'h1000, 16'h2000, 16'h3000, 16'h1000,
                                UNITY_GAIN, UNITY_GAIN, UNITY_GAIN));
    endtask

    // Gains above one push channels into saturation; a zero gain holds a channel.
    task automatic test_high_gain();
        send_sample(make_sample(1'b1, 16'h0100, 16'h0100, 16'h0100, 16'h8000,
                                16'hFFFF, 16'h8000, 16'h0000));
        send_sample(make_sample(1'b0, 16'h2000, 16'h2000, 16'h2000, 16'h4000,
                                16'hFFFF, 16'h8000, 16'h0000));
        send_sample(make_sample(1'b0, 16'h8000, 16'h8000, 16'h8000, 16'h4000,
                                16'h7FFF, 16'h1FFF, 16'h0FFF));
        send_sample(make_sample(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h2000,
                                16'hFFFF, 16'hFFFF, 16'hFFFF));
    endtask

    // Unity-gain layers build up toward full scale and then clamp there.
    task automatic test_saturation();
        send_sample(make_sample(1'b1, 16'hFFFF, 16'hC000, 16'h8000, 16'h4000,
                                UNITY_GAIN, UNITY_GAIN, UNITY_GAIN));
        send_sample(make_sample(1'b0, 16'hFFFF, 16'hC000, 16'h8000, 16'h4000,
                                UNITY_GAIN, UNITY_GAIN, UNITY_GAIN));
        send_sample(make_sample(1'b0, 16'hFFFF, 16'hC000, 16'h8000, 16'h4000,
                                16'h3000, 16'h3000, 16'h3000));
        send_sample(make_sample(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000,
                                16'hF000, 16'hF000, 16'hF000));
        send_sample(make_sample(1'b0, 16'h0001, 16'h0001, 16'h0001, 16'h0001,
                                UNITY_GAIN, UNITY_GAIN, UNITY_GAIN));
    endtask

    // Well-formed rays: a start mark, then a run of samples with random content.
    task automatic test_composited_rays(input int unsigned count);
        int unsigned sent;
        int unsigned ray_length;
        sent = 0;
        while (sent < count) begin
            ray_length = $urandom_range(1, 16);
            for (int unsigned i = 0; i < ray_length; i++) begin
                send_sample(random_sample(i == 0));
                sent++;
            end
        end
    endtask

    // Start marks at random, including long runs without any.
    task automatic test_unmarked_noise(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            send_sample(random_sample(1'($urandom_range(0, 1))));
        end
    endtask

    // Random output stalls, none while the steady stretch runs.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= !steady && ($urandom_range(0, 99) < 11);
        end
    end

    // Compares every accepted pixel with the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected transaction: red %0d green %0d blue %0d trans %0d",
                         $time, acc_red_out, acc_green_out, acc_blue_out, transmittance_out);
                error_count++;
            end else begin
                oldest_pixel = expected_pixels.pop_front();
                if (acc_red_out !== oldest_pixel.red) begin
                    $display("%0t: acc_red_out expected %0d actual %0d",
                             $time, oldest_pixel.red, acc_red_out);
                    error_count++;
                end
                if (acc_green_out !== oldest_pixel.green) begin
                    $display("%0t: acc_green_out expected %0d actual %0d",
                             $time, oldest_pixel.green, acc_green_out);
                    error_count++;
                end
                if (acc_blue_out !== oldest_pixel.blue) begin
                    $display("%0t: acc_blue_out expected %0d actual %0d",
                             $time, oldest_pixel.blue, acc_blue_out);
                    error_count++;
                end
                if (transmittance_out !== oldest_pixel.transmittance) begin
                    $display("%0t: transmittance_out expected %0d actual %0d",
                             $time, oldest_pixel.transmittance, transmittance_out);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("front_to_back_color_accumulator_tb: done, errors");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_ray();
        test_field_extremes();
        test_opaque_sample();
        test_high_gain();
        test_saturation();
        wait_for_pixels();

        test_composited_rays(600);
        wait_for_pixels();
        steady <= 1'b1;
        test_composited_rays(200);
        steady <= 1'b0;
        test_unmarked_noise(150);
        wait_for_pixels();
        test_composited_rays(180);

        // Let the last pixels come home, then give stray outputs time to show.
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("front_to_back_color_accumulator_tb: done, clean");
        end else begin
            $display("front_to_back_color_accumulator_tb: done, errors");
        end
        $finish;
    end

endmodule
